// ===== rtl/core/c2p_pkg.sv =====
// Shared types, constants and table functions of the Cartesian to polar bin mapper.
`timescale 1ns / 1ps
package c2p_pkg;

	localparam int COORD_W      = 13;
	localparam int SQ_W         = 24;
	localparam int SQ_STEPS     = 12;
	localparam int ROOT_W       = 12;
	localparam int RD_STEPS     = 12;
	localparam int RING_W       = 8;
	localparam int CORDIC_STEPS = 56;
	localparam int COORD_FRAC   = 48;
	localparam int ANGLE_FRAC   = 60;
	localparam int SEC_Q_W      = 9;

	localparam logic signed [63:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
	localparam logic [63:0]        HALF_PI_Q60    = 64'h1921FB54442D1846;
	localparam logic [63:0]        TWO_PI_Q60     = 64'h6487ED5110B4611A;

	typedef struct packed {
		logic signed [63:0]   x;
		logic signed [63:0]   y;
		logic signed [63:0]   z;
		logic [1:0]           quad;
		logic                 special;
		logic [SEC_Q_W-1:0]   sp_sector;
		logic [SQ_W-1:0]      sq_n;
		logic [SQ_W-1:0]      sq_root;
		logic [ROOT_W-1:0]    rnum;
		logic [ROOT_W-1:0]    rrem;
		logic [ROOT_W-1:0]    rq;
		logic                 rzero;
		logic [RING_W-1:0]    ring;
		logic [63:0]          theta;
		logic [SEC_Q_W-1:0]   sq;
	} c2p_item_t;

	// Arctangent of 2^-i in Q4.60, from the truncated alternating series.
	function automatic logic signed [63:0] c2p_atan(input int i);
		logic signed [63:0] acc;
		logic signed [63:0] term;
		int e;
		acc = '0;
		if (i == 0) begin
			acc = QUARTER_PI_Q60;
		end else begin
			for (int k = 0; k < 32; k++) begin
				e = ANGLE_FRAC - i * (2 * k + 1);
				if (e >= 0) begin
					term = 64'((64'd1 << e) / 64'(2 * k + 1));
					if ((k % 2) == 1) acc = acc - term;
					else acc = acc + term;
				end
			end
		end
		return acc;
	endfunction

endpackage

// ===== rtl/core/c2p_front.sv =====
// Input stage: centres and folds the pixel and forms the squared radius.
`timescale 1ns / 1ps
module c2p_front #(
	parameter int HALF_SCREEN  = 480,
	parameter int SECTOR_COUNT = 180
) (
	input  logic                clk,
	input  logic                en,
	input  logic [9:0]          pixel_x,
	input  logic [9:0]          pixel_y,
	output c2p_pkg::c2p_item_t  q
);
	localparam int CW = c2p_pkg::COORD_W;

	logic signed [CW-1:0]  dx, dy, u, v;
	logic signed [2*CW-1:0] dx2, dy2;
	logic [1:0]            quad;
	logic [2:0]            oct;
	logic [11:0]           oct_prod;
	logic                  centre, exact;
	c2p_pkg::c2p_item_t    nxt;

	always_comb begin
		dx = $signed({3'b000, pixel_x}) - $signed(CW'(HALF_SCREEN));
		dy = $signed({3'b000, pixel_y}) - $signed(CW'(HALF_SCREEN));
		dx2 = (2*CW)'(dx) * (2*CW)'(dx);
		dy2 = (2*CW)'(dy) * (2*CW)'(dy);
		if (dx > 0 && dy >= 0) begin
			quad = 2'd0; u = dx; v = dy;
		end else if (dx <= 0 && dy > 0) begin
			quad = 2'd1; u = dy; v = -dx;
		end else if (dx < 0 && dy <= 0) begin
			quad = 2'd2; u = -dx; v = -dy;
		end else begin
			quad = 2'd3; u = -dy; v = dx;
		end
		centre = (dx == 0) && (dy == 0);
		exact  = (v == 0) || (u == v);
		oct = {quad, (v != 0)};
		oct_prod = 12'({9'd0, oct} * 12'(SECTOR_COUNT));

		nxt = '0;
		nxt.x = 64'(u) <<< c2p_pkg::COORD_FRAC;
		nxt.y = 64'(v) <<< c2p_pkg::COORD_FRAC;
		nxt.quad = quad;
		nxt.special = centre | exact;
		nxt.sp_sector = centre ? c2p_pkg::SEC_Q_W'(SECTOR_COUNT / 4)
		                       : c2p_pkg::SEC_Q_W'(oct_prod >> 3);
		nxt.sq_n = c2p_pkg::SQ_W'(dx2) + c2p_pkg::SQ_W'(dy2);
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end
endmodule

// ===== rtl/core/c2p_cell.sv =====
// Cell: a CORDIC rotation; early cells add a square-root or ring-division digit.
`timescale 1ns / 1ps
module c2p_cell #(
	parameter int STEP       = 0,
	parameter int RING_STEP  = 8,
	parameter int RING_HALF  = 4,
	parameter int RING_COUNT = 60
) (
	input  logic                clk,
	input  logic                en,
	input  c2p_pkg::c2p_item_t  d,
	output c2p_pkg::c2p_item_t  q
);
	localparam int SQS = c2p_pkg::SQ_STEPS;
	localparam int RDS = c2p_pkg::RD_STEPS;
	localparam int RW  = c2p_pkg::ROOT_W;
	localparam int SQ_SH = (STEP < SQS) ? (c2p_pkg::SQ_W - 2 - 2 * STEP) : 0;
	localparam logic [c2p_pkg::SQ_W-1:0] SQ_BIT = c2p_pkg::SQ_W'(1) << SQ_SH;
	localparam logic signed [63:0] ATAN = c2p_pkg::c2p_atan(STEP);

	logic signed [63:0]        xs, ys;
	logic [c2p_pkg::SQ_W:0]    sq_sum;
	logic [RW-1:0]             num_in, rem_in, q_in;
	logic                      zero_in;
	logic [RW:0]               rem_sh;
	logic [RW:0]               ring_full;
	c2p_pkg::c2p_item_t        nxt;

	always_comb begin
		nxt = d;
		xs = d.x >>> STEP;
		ys = d.y >>> STEP;
		if (!d.y[63]) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + ATAN;
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - ATAN;
		end

		sq_sum = {1'b0, d.sq_root} + {1'b0, SQ_BIT};
		num_in = d.rnum;
		rem_in = d.rrem;
		q_in = d.rq;
		zero_in = d.rzero;
		rem_sh = '0;
		ring_full = '0;
		if (STEP < SQS) begin
			if ({1'b0, d.sq_n} >= sq_sum) begin
				nxt.sq_n = d.sq_n - sq_sum[c2p_pkg::SQ_W-1:0];
				nxt.sq_root = (d.sq_root >> 1) + SQ_BIT;
			end else begin
				nxt.sq_root = d.sq_root >> 1;
			end
		end else if (STEP < SQS + RDS) begin
			if (STEP == SQS) begin
				zero_in = d.sq_root[RW-1:0] <= RW'(RING_HALF);
				num_in = d.sq_root[RW-1:0] - RW'(RING_HALF);
				rem_in = '0;
				q_in = '0;
			end
			rem_sh = {rem_in, num_in[RW-1]};
			nxt.rzero = zero_in;
			nxt.rnum = num_in << 1;
			if (rem_sh >= (RW+1)'(RING_STEP)) begin
				nxt.rrem = RW'(rem_sh - (RW+1)'(RING_STEP));
				nxt.rq = {q_in[RW-2:0], 1'b1};
			end else begin
				nxt.rrem = RW'(rem_sh);
				nxt.rq = {q_in[RW-2:0], 1'b0};
			end
		end else if (STEP == SQS + RDS) begin
			ring_full = {1'b0, d.rq} + (RW+1)'(1);
			if (d.rzero) nxt.ring = '0;
			else if (ring_full >= (RW+1)'(RING_COUNT))
				nxt.ring = c2p_pkg::RING_W'(RING_COUNT - 1);
			else nxt.ring = c2p_pkg::RING_W'(ring_full);
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end
endmodule

// ===== rtl/core/c2p_div_cell.sv =====
// One restoring-division digit that turns the angle into a sector number.
`timescale 1ns / 1ps
module c2p_div_cell #(
	parameter int STEP         = 0,
	parameter int SECTOR_COUNT = 180
) (
	input  logic                clk,
	input  logic                en,
	input  c2p_pkg::c2p_item_t  d,
	output c2p_pkg::c2p_item_t  q
);
	localparam int QW = c2p_pkg::SEC_Q_W;
	localparam logic [63:0] UNIT = c2p_pkg::TWO_PI_Q60 / 64'(SECTOR_COUNT);
	localparam logic [72:0] DIVS = 73'(UNIT) << (QW - 1 - STEP);

	logic [63:0]        theta_in;
	logic [QW-1:0]      q_in;
	c2p_pkg::c2p_item_t nxt;

	always_comb begin
		nxt = d;
		theta_in = d.theta;
		q_in = d.sq;
		if (STEP == 0) begin
			theta_in = 64'({62'd0, d.quad} * c2p_pkg::HALF_PI_Q60);
			if (d.z > 0) theta_in = theta_in + d.z;
			q_in = '0;
		end
		if ({9'd0, theta_in} >= DIVS) begin
			nxt.theta = theta_in - DIVS[63:0];
			nxt.sq = {q_in[QW-2:0], 1'b1};
		end else begin
			nxt.theta = theta_in;
			nxt.sq = {q_in[QW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end
endmodule

// ===== rtl/core/cartesian_to_polar_bin_mapper.sv =====
// Top level of the Cartesian to polar bin mapper: cell chain and request flow control.
`timescale 1ns / 1ps
// A request passes the front stage, 56 CORDIC cells, 9 sector-division cells and the output register.
// Throughput: one request per cycle while the output is not stalled.
// Each chain stage takes new data whenever it is empty or its successor moves on.
// Reset (arst_n low, asynchronous) empties every stage; the data registers are not reset.
module cartesian_to_polar_bin_mapper #(
	parameter int SCREEN_SIZE  = 960,
	parameter int RING_COUNT   = 60,
	parameter int SECTOR_COUNT = 180
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // pixel_x[9:0], pixel_y[19:10], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // ring_index[5:0], sector_index[13:6], zero pad
);
	localparam int HALF_SCREEN = SCREEN_SIZE / 2;
	localparam int RSTEP0 = HALF_SCREEN / RING_COUNT;
	localparam int RING_STEP = (RSTEP0 == 0) ? 1 : RSTEP0;
	localparam int RING_HALF = RING_STEP / 2;
	localparam int NC = c2p_pkg::CORDIC_STEPS;
	localparam int ND = c2p_pkg::SEC_Q_W;
	localparam int NS = 1 + NC + ND;

	c2p_pkg::c2p_item_t item [NS];
	logic [NS:0]        valid_q;
	logic [NS:0]        ready;
	logic [c2p_pkg::SEC_Q_W-1:0] sector;
	logic [15:0]        tdata_q;

	always_comb begin
		ready[NS] = !valid_q[NS] || m_axis_tready;
		for (int k = NS - 1; k >= 0; k--) ready[k] = !valid_q[k] || ready[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ready[0]) valid_q[0] <= s_axis_tvalid;
			for (int k = 1; k <= NS; k++) begin
				if (ready[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	c2p_front #(.HALF_SCREEN(HALF_SCREEN), .SECTOR_COUNT(SECTOR_COUNT)) u_front (
		.clk     (clk),
		.en      (ready[0] && s_axis_tvalid),
		.pixel_x (s_axis_tdata[9:0]),
		.pixel_y (s_axis_tdata[19:10]),
		.q       (item[0])
	);

	for (genvar g = 0; g < NC; g++) begin : g_cell
		c2p_cell #(
			.STEP(g), .RING_STEP(RING_STEP), .RING_HALF(RING_HALF), .RING_COUNT(RING_COUNT)
		) u_cell (
			.clk (clk),
			.en  (ready[g+1] && valid_q[g]),
			.d   (item[g]),
			.q   (item[g+1])
		);
	end

	for (genvar g = 0; g < ND; g++) begin : g_div
		c2p_div_cell #(.STEP(g), .SECTOR_COUNT(SECTOR_COUNT)) u_div (
			.clk (clk),
			.en  (ready[NC+g+1] && valid_q[NC+g]),
			.d   (item[NC+g]),
			.q   (item[NC+g+1])
		);
	end

	always_comb begin
		if (item[NS-1].special) sector = item[NS-1].sp_sector;
		else if (item[NS-1].sq >= c2p_pkg::SEC_Q_W'(SECTOR_COUNT))
			sector = item[NS-1].sq - c2p_pkg::SEC_Q_W'(SECTOR_COUNT);
		else sector = item[NS-1].sq;
	end

	always_ff @(posedge clk) begin
		if (ready[NS] && valid_q[NS-1])
			tdata_q <= {2'b00, sector[7:0], item[NS-1].ring[5:0]};
	end

	assign s_axis_tready = ready[0];
	assign m_axis_tvalid = valid_q[NS];
	assign m_axis_tdata  = tdata_q;
endmodule

// ===== rtl/core/c2p_checker.sv =====
// Port checker for the Cartesian to polar bin mapper, bound to the top level.
`timescale 1ns / 1ps
module c2p_checker #(
	parameter int RING_COUNT   = 60,
	parameter int SECTOR_COUNT = 180
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or vanished");

	a_ring: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(m_axis_tdata[5:0]) < RING_COUNT)
		else $error("ring beyond last ring");

	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(m_axis_tdata[13:6]) < SECTOR_COUNT)
		else $error("sector beyond last sector");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:14] == 2'b00)
		else $error("pad bits not zero");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked while no result waits");
endmodule

bind cartesian_to_polar_bin_mapper c2p_checker #(
	.RING_COUNT(RING_COUNT), .SECTOR_COUNT(SECTOR_COUNT)
) u_c2p_checker (.*);

// ===== tb/tb_cartesian_to_polar_bin_mapper.sv =====
// Self-checking testbench of the Cartesian to polar bin mapper: directed and random pixels.
`timescale 1ns / 1ps
module tb_cartesian_to_polar_bin_mapper;

	localparam int SCREEN    = 960;
	localparam int RINGS     = 60;
	localparam int SECTORS   = 180;
	localparam int N_RANDOM  = 1130;
	localparam int MAX_CYCLE = 400000;
	localparam int STEPS     = 56;

	typedef struct {
		logic [5:0] ring;
		logic [7:0] sector;
	} bin_t;

	typedef struct {
		logic [9:0] px;
		logic [9:0] py;
		bit         typed;
		bin_t       bin;
	} pixel_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	longint      arctan_q60 [STEPS];
	bin_t        pending_bins [$];
	int          mismatches = 0;
	int          bins_seen = 0;
	int          cycles = 0;
	bit          steady_sink = 1'b0;

	cartesian_to_polar_bin_mapper #(
		.SCREEN_SIZE(SCREEN), .RING_COUNT(RINGS), .SECTOR_COUNT(SECTORS)
	) dut (.*);

	always #5 clk = ~clk;

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 40;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic bin_t map_pixel(logic [9:0] px, logic [9:0] py);
		int dx, dy, u, v, quad, stepw, r, ring, sector;
		longint x, y, z, xs, ys;
		longint unsigned theta, unit;
		bin_t b;
		dx = int'(px) - SCREEN / 2;
		dy = int'(py) - SCREEN / 2;
		r = int'(isqrt(longint'(dx * dx + dy * dy)));
		stepw = (SCREEN / 2) / RINGS;
		if (stepw == 0) stepw = 1;
		ring = (r <= stepw / 2) ? 0 : (r - stepw / 2) / stepw + 1;
		if (ring >= RINGS) ring = RINGS - 1;
		if (dx == 0 && dy == 0) begin
			sector = SECTORS / 4;
		end else begin
			if (dx > 0 && dy >= 0) begin quad = 0; u = dx; v = dy; end
			else if (dx <= 0 && dy > 0) begin quad = 1; u = dy; v = -dx; end
			else if (dx < 0 && dy <= 0) begin quad = 2; u = -dx; v = -dy; end
			else begin quad = 3; u = -dy; v = dx; end
			if (v == 0 || u == v) begin
				sector = ((2 * quad + (v == 0 ? 0 : 1)) * SECTORS) / 8;
			end else begin
				x = longint'(u) <<< c2p_pkg::COORD_FRAC;
				y = longint'(v) <<< c2p_pkg::COORD_FRAC;
				z = 0;
				for (int i = 0; i < STEPS; i++) begin
					xs = x >>> i;
					ys = y >>> i;
					if (y >= 0) begin
						x += ys; y -= xs; z += arctan_q60[i];
					end else begin
						x -= ys; y += xs; z -= arctan_q60[i];
					end
				end
				theta = longint'(quad) * c2p_pkg::HALF_PI_Q60;
				if (z > 0) theta += z;
				unit = c2p_pkg::TWO_PI_Q60 / SECTORS;
				sector = int'(theta / unit);
			end
			sector = sector % SECTORS;
		end
		b.ring = ring[5:0];
		b.sector = sector[7:0];
		return b;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch in %s at result %0d: got %0d, expected %0d",
			what, bins_seen, got, want);
		mismatches++;
	endtask

	task automatic send_pixel(logic [9:0] px, logic [9:0] py, bit typed, bin_t bin,
			bit may_idle);
		while (may_idle && $urandom_range(0, 99) < 27) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, py, px};
		do @(posedge clk); while (!s_axis_tready);
		pending_bins.push_back(typed ? bin : map_pixel(px, py));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLE) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) m_axis_tready <= steady_sink || ($urandom_range(0, 99) >= 27);
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_bins.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				bin_t want;
				want = pending_bins.pop_front();
				if (m_axis_tdata[5:0] != want.ring)
					report_mismatch("ring_index", m_axis_tdata[5:0], want.ring);
				if (m_axis_tdata[13:6] != want.sector)
					report_mismatch("sector_index", m_axis_tdata[13:6], want.sector);
				if (m_axis_tdata[15:14] != 2'b0)
					report_mismatch("tdata padding", m_axis_tdata[15:14], 0);
			end
			bins_seen++;
		end
	end

	pixel_row_t directed [] = '{
		'{10'd480,  10'd480,  1, '{6'd0,  8'd45}},
		'{10'd1023, 10'd480,  1, '{6'd59, 8'd0}},
		'{10'd480,  10'd959,  1, '{6'd59, 8'd45}},
		'{10'd0,    10'd480,  1, '{6'd59, 8'd90}},
		'{10'd480,  10'd0,    1, '{6'd59, 8'd135}},
		'{10'd580,  10'd580,  1, '{6'd18, 8'd22}},
		'{10'd0,    10'd0,    1, '{6'd59, 8'd112}},
		'{10'd1023, 10'd1023, 1, '{6'd59, 8'd22}},
		'{10'd484,  10'd480,  1, '{6'd0,  8'd0}},
		'{10'd485,  10'd480,  1, '{6'd1,  8'd0}},
		'{10'd492,  10'd480,  1, '{6'd2,  8'd0}},
		'{10'd0,    10'd1023, 0, '{6'd0,  8'd0}},
		'{10'd1023, 10'd0,    0, '{6'd0,  8'd0}},
		'{10'd380,  10'd580,  1, '{6'd18, 8'd67}},
		'{10'd380,  10'd380,  1, '{6'd18, 8'd112}},
		'{10'd580,  10'd380,  1, '{6'd18, 8'd157}},
		'{10'd481,  10'd479,  1, '{6'd0,  8'd157}},
		'{10'd481,  10'd481,  0, '{6'd0,  8'd0}},
		'{10'd959,  10'd481,  0, '{6'd0,  8'd0}},
		'{10'd959,  10'd479,  0, '{6'd0,  8'd0}},
		'{10'd481,  10'd0,    0, '{6'd0,  8'd0}},
		'{10'd479,  10'd0,    0, '{6'd0,  8'd0}},
		'{10'd682,  10'd511,  0, '{6'd0,  8'd0}},
		'{10'd341,  10'd170,  0, '{6'd0,  8'd0}}
	};

	initial begin
		bin_t none;
		logic [9:0] px, py;
		int e;
		longint acc;
		none = '{6'd0, 8'd0};
		arctan_q60[0] = c2p_pkg::QUARTER_PI_Q60;
		for (int i = 1; i < STEPS; i++) begin
			acc = 0;
			for (int k = 0; k < 32; k++) begin
				e = c2p_pkg::ANGLE_FRAC - i * (2 * k + 1);
				if (e < 0) break;
				if (k % 2) acc -= (64'sd1 <<< e) / (2 * k + 1);
				else acc += (64'sd1 <<< e) / (2 * k + 1);
			end
			arctan_q60[i] = acc;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_pixel(directed[i].px, directed[i].py, directed[i].typed, directed[i].bin, 1);

		for (int n = 0; n < N_RANDOM; n++) begin
			steady_sink = (n >= 400 && n < 600);
			if (n == 700) begin
				s_axis_tvalid <= 1'b0;
				wait (pending_bins.size() == 0);
				@(posedge clk);
			end
			if ($urandom_range(0, 99) < 80) begin
				px = 10'($urandom_range(0, SCREEN - 1));
				py = 10'($urandom_range(0, SCREEN - 1));
			end else if ($urandom_range(0, 1)) begin
				e = $urandom_range(0, 200);
				px = 10'(SCREEN / 2 + ($urandom_range(0, 1) ? e : -e));
				py = 10'(SCREEN / 2 + ($urandom_range(0, 1) ? e : -e));
			end else begin
				px = 10'($urandom_range(0, 1023));
				py = 10'($urandom_range(0, 1023));
			end
			send_pixel(px, py, 0, none, !(n >= 400 && n < 600));
		end
		s_axis_tvalid <= 1'b0;
		steady_sink = 1'b0;
		wait (pending_bins.size() == 0);
		repeat (100) @(posedge clk);
		$display("Checked %0d bins: axes, diagonals, centre, ring edges and saturation,",
			bins_seen);
		$display("then random pixels across and beyond the screen with random stalls.");
		if (mismatches == 0 && pending_bins.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
